// File: src/bmhq_pkg.sv
// bmhq_pkg: shared types and constants for the binary min-heap queue
// no dependencies; every other file but bmhq_fifo refers to it by scoped names

package bmhq_pkg;

   // operation carried by an input beat
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // status reported with every result beat
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // control half of a classified command
   typedef struct packed {
      op_type     op;
      status_type status;
   } cmd_ctrl_type;

   // heap engine sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_UP_CMP,
      BK_RM_LOAD,
      BK_DN_CMP,
      BK_WR_FIN
   } back_state_type;

   localparam int CTRL_BITS   = $bits(cmd_ctrl_type);
   localparam int STATUS_BITS = $bits(status_type);

endpackage

// File: src/bmhq_fifo.sv
// bmhq_fifo: small register queue used for commands and for results
// depends on nothing; payload is carried as a plain vector

module bmhq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: src/bmhq_front.sv
// bmhq_front: accepts input beats and classifies them against the projected fill
// depends on bmhq_pkg; feeds the command queue

module bmhq_front #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 mode,
   input  logic [KEY_WIDTH-1:0] key,
   input  logic                 cmd_full,
   output logic                 cmd_wr,
   output logic [KEY_WIDTH+$clog2(CAPACITY+1)+bmhq_pkg::CTRL_BITS-1:0] cmd_data
);

   localparam int FW = $clog2(CAPACITY + 1);

   logic [FW-1:0]          count_ff, count_in;
   logic [FW-1:0]          fill_after;
   bmhq_pkg::cmd_ctrl_type ctrl;
   logic                   accept;

   assign accept = push && !cmd_full;
   assign cmd_wr = accept;

   // classify the beat and work out the fill it leaves
   always_comb begin
      ctrl.op     = bmhq_pkg::OP_INSERT;
      ctrl.status = bmhq_pkg::ST_DONE;
      fill_after  = count_ff;
      if (mode == 1'b0) begin
         if (count_ff == FW'(CAPACITY)) begin
            ctrl.status = bmhq_pkg::ST_FULL;
         end else begin
            fill_after = count_ff + FW'(1);
         end
      end else begin
         ctrl.op = bmhq_pkg::OP_REMOVE;
         if (count_ff == '0) begin
            ctrl.status = bmhq_pkg::ST_EMPTY;
         end else begin
            fill_after = count_ff - FW'(1);
         end
      end
   end

   assign count_in = accept ? fill_after : count_ff;
   assign cmd_data = {key, fill_after, ctrl};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: src/bmhq_back.sv
// bmhq_back: heap engine, sifts keys through the heap memory one level a cycle
// depends on bmhq_pkg; reads the command queue and writes the result queue

module bmhq_back #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_empty,
   input  logic [KEY_WIDTH+$clog2(CAPACITY+1)+bmhq_pkg::CTRL_BITS-1:0] cmd_data,
   output logic cmd_rd,
   input  logic rsp_full,
   output logic rsp_wr,
   output logic [KEY_WIDTH+$clog2(CAPACITY+1)+bmhq_pkg::STATUS_BITS-1:0] rsp_data
);

   localparam int FW    = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);
   localparam int CMD_W = KEY_WIDTH + FW + bmhq_pkg::CTRL_BITS;

   // command fields
   logic [KEY_WIDTH-1:0]   cmd_key;
   logic [FW-1:0]          cmd_fill;
   bmhq_pkg::cmd_ctrl_type cmd_ctrl;

   assign cmd_key  = cmd_data[CMD_W-1 -: KEY_WIDTH];
   assign cmd_fill = cmd_data[bmhq_pkg::CTRL_BITS +: FW];
   assign cmd_ctrl = cmd_data[bmhq_pkg::CTRL_BITS-1:0];

   // heap memory, position p lives at address p-1
   logic [KEY_WIDTH-1:0] heap_mem [CAPACITY];
   logic [KEY_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]        rd_a_addr, rd_b_addr, wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 wr_en;

   // sequencer registers
   bmhq_pkg::back_state_type state_ff, state_in;
   logic [FW-1:0]        pos_ff, pos_in;
   logic [FW-1:0]        cnt_ff, cnt_in;
   logic [KEY_WIDTH-1:0] cur_ff, cur_in;
   logic [KEY_WIDTH-1:0] res_key_ff, res_key_in;

   // result beat being pushed
   logic [KEY_WIDTH-1:0] push_key;
   logic [FW-1:0]        push_fill;
   bmhq_pkg::status_type push_status;

   logic go;
   assign go = !cmd_empty && !rsp_full;

   // sift-up view
   logic [FW-1:0] in_parent, in_parent_m1, up_parent, up_gparent, up_gparent_m1, pos_m1;
   logic          up_gt;

   assign in_parent     = cmd_fill >> 1;
   assign in_parent_m1  = in_parent - FW'(1);
   assign up_parent     = pos_ff >> 1;
   assign up_gparent    = up_parent >> 1;
   assign up_gparent_m1 = up_gparent - FW'(1);
   assign pos_m1        = pos_ff - FW'(1);
   assign up_gt         = $signed(rd_a_ff) > $signed(cur_ff);

   // sift-down view: left child wins a tie
   logic [FW:0]          dn_l, dn_r, cnt_x, ch_l, ch_l_m1;
   logic [FW-1:0]        ch_pos;
   logic [KEY_WIDTH-1:0] ch_key;
   logic                 has_r, pick_r, dn_gt, ch_has_kid;

   assign dn_l       = {pos_ff, 1'b0};
   assign dn_r       = {pos_ff, 1'b1};
   assign cnt_x      = {1'b0, cnt_ff};
   assign has_r      = dn_r <= cnt_x;
   assign pick_r     = has_r && ($signed(rd_a_ff) > $signed(rd_b_ff));
   assign ch_key     = pick_r ? rd_b_ff : rd_a_ff;
   assign ch_pos     = pick_r ? dn_r[FW-1:0] : dn_l[FW-1:0];
   assign dn_gt      = $signed(cur_ff) > $signed(ch_key);
   assign ch_l       = {ch_pos, 1'b0};
   assign ch_l_m1    = ch_l - (FW+1)'(1);
   assign ch_has_kid = ch_l <= cnt_x;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmhq_pkg::BK_IDLE: begin
            if (go && cmd_ctrl.status == bmhq_pkg::ST_DONE) begin
               if (cmd_ctrl.op == bmhq_pkg::OP_REMOVE) begin
                  state_in = bmhq_pkg::BK_RM_LOAD;
               end else if (cmd_fill != FW'(1)) begin
                  state_in = bmhq_pkg::BK_UP_CMP;
               end
            end
         end
         bmhq_pkg::BK_UP_CMP: begin
            if (!up_gt) begin
               state_in = bmhq_pkg::BK_IDLE;
            end else if (up_parent == FW'(1)) begin
               state_in = bmhq_pkg::BK_WR_FIN;
            end
         end
         bmhq_pkg::BK_RM_LOAD: begin
            state_in = (cnt_ff >= FW'(2)) ? bmhq_pkg::BK_DN_CMP : bmhq_pkg::BK_IDLE;
         end
         bmhq_pkg::BK_DN_CMP: begin
            if (!dn_gt) begin
               state_in = bmhq_pkg::BK_IDLE;
            end else if (!ch_has_kid) begin
               state_in = bmhq_pkg::BK_WR_FIN;
            end
         end
         bmhq_pkg::BK_WR_FIN: begin
            state_in = bmhq_pkg::BK_IDLE;
         end
         default: begin
            state_in = bmhq_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      cmd_rd      = 1'b0;
      rsp_wr      = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = pos_m1[AW-1:0];
      wr_data     = cur_ff;
      rd_a_addr   = '0;
      rd_b_addr   = '0;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      res_key_in  = res_key_ff;
      push_key    = res_key_ff;
      push_fill   = cnt_ff;
      push_status = bmhq_pkg::ST_DONE;
      case (state_ff)
         bmhq_pkg::BK_IDLE: begin
            push_key    = '0;
            push_fill   = cmd_fill;
            push_status = cmd_ctrl.status;
            if (go) begin
               cmd_rd     = 1'b1;
               cnt_in     = cmd_fill;
               cur_in     = cmd_key;
               pos_in     = cmd_fill;
               res_key_in = '0;
               if (cmd_ctrl.status != bmhq_pkg::ST_DONE) begin
                  rsp_wr = 1'b1;
               end else if (cmd_ctrl.op == bmhq_pkg::OP_REMOVE) begin
                  // root and last entry
                  rd_a_addr = '0;
                  rd_b_addr = cmd_fill[AW-1:0];
               end else if (cmd_fill == FW'(1)) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = cmd_key;
                  rsp_wr  = 1'b1;
               end else begin
                  rd_a_addr = in_parent_m1[AW-1:0];
               end
            end
         end
         bmhq_pkg::BK_UP_CMP: begin
            wr_en = 1'b1;
            if (up_gt) begin
               // parent moves down into the hole
               wr_data   = rd_a_ff;
               pos_in    = up_parent;
               rd_a_addr = up_gparent_m1[AW-1:0];
            end else begin
               rsp_wr = 1'b1;
            end
         end
         bmhq_pkg::BK_RM_LOAD: begin
            res_key_in = rd_a_ff;
            push_key   = rd_a_ff;
            cur_in     = rd_b_ff;
            pos_in     = FW'(1);
            rd_a_addr  = AW'(1);
            rd_b_addr  = AW'(2);
            if (cnt_ff == FW'(1)) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = rd_b_ff;
               rsp_wr  = 1'b1;
            end else if (cnt_ff == '0) begin
               rsp_wr = 1'b1;
            end
         end
         bmhq_pkg::BK_DN_CMP: begin
            wr_en = 1'b1;
            if (dn_gt) begin
               // smaller child moves up into the hole
               wr_data   = ch_key;
               pos_in    = ch_pos;
               rd_a_addr = ch_l_m1[AW-1:0];
               rd_b_addr = ch_l[AW-1:0];
            end else begin
               rsp_wr = 1'b1;
            end
         end
         bmhq_pkg::BK_WR_FIN: begin
            wr_en  = 1'b1;
            rsp_wr = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rsp_data = {push_key, push_fill, push_status};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      cur_ff     <= cur_in;
      res_key_ff <= res_key_in;
   end

   // memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

endmodule

// File: src/binary_min_heap_queue.sv
// binary_min_heap_queue: min-priority queue of signed keys in a binary heap
// depends on bmhq_pkg, bmhq_fifo, bmhq_front and bmhq_back
//
//   channel    handshake          beat fields
//   request    push / full        req_mode, req_key_in
//   response   empty / pop        rsp_key_out, rsp_status, rsp_fill_level
//
// a full-heap insert or empty-heap remove is answered from the idle state in the engine
// insert at the root is written and answered from idle; else the key climbs level by level
// remove loads root and last entry and answers there with at most one key left, else descends
// level by level; each level is a registered heap memory read feeding the compares and one write
// two-beat queues sit between front and engine and at the result side
// synchronous reset empties both queues and the heap; stalled results hold

module binary_min_heap_queue #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_mode,
   input  logic [KEY_WIDTH-1:0]          req_key_in,
   output logic                          empty,
   input  logic                          pop,
   output logic [KEY_WIDTH-1:0]          rsp_key_out,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_fill_level
);

   localparam int FW    = $clog2(CAPACITY + 1);
   localparam int CMD_W = KEY_WIDTH + FW + bmhq_pkg::CTRL_BITS;
   localparam int RSP_W = KEY_WIDTH + FW + bmhq_pkg::STATUS_BITS;

   logic             cmd_wr, cmd_full, cmd_rd, cmd_empty;
   logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
   logic             rsp_wr, rsp_full;
   logic [RSP_W-1:0] rsp_wdata, rsp_rdata;

   // front: accept and classify
   bmhq_front #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .mode     (req_mode),
      .key      (req_key_in),
      .cmd_full (cmd_full),
      .cmd_wr   (cmd_wr),
      .cmd_data (cmd_wdata)
   );

   assign full = cmd_full;

   // command queue
   bmhq_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_wr),
      .wr_data (cmd_wdata),
      .full    (cmd_full),
      .rd_en   (cmd_rd),
      .rd_data (cmd_rdata),
      .empty   (cmd_empty)
   );

   // back: heap engine
   bmhq_back #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_rd    (cmd_rd),
      .rsp_full  (rsp_full),
      .rsp_wr    (rsp_wr),
      .rsp_data  (rsp_wdata)
   );

   // result queue
   bmhq_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_wr),
      .wr_data (rsp_wdata),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_rdata),
      .empty   (empty)
   );

   assign rsp_key_out    = rsp_rdata[RSP_W-1 -: KEY_WIDTH];
   assign rsp_fill_level = rsp_rdata[bmhq_pkg::STATUS_BITS +: FW];
   assign rsp_status     = rsp_rdata[bmhq_pkg::STATUS_BITS-1:0];

endmodule

// File: src/bmhq_checker.sv
// bmhq_checker: port-level assertions for the heap queue, bound to the top level
// depends on bmhq_pkg and binary_min_heap_queue

module bmhq_checker #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic [KEY_WIDTH-1:0]          rsp_key_out,
   input logic [1:0]                    rsp_status,
   input logic [$clog2(CAPACITY+1)-1:0] rsp_fill_level
);

   localparam int FW = $clog2(CAPACITY + 1);

   // reset leaves both queues empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not cleared by reset");

   // a waiting result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_key_out) && $stable(rsp_status)
                         && $stable(rsp_fill_level))
      else $error("result beat changed while stalled");

   // only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_status == bmhq_pkg::ST_DONE || rsp_status == bmhq_pkg::ST_EMPTY
                 || rsp_status == bmhq_pkg::ST_FULL)
      else $error("undefined status code");

   // remove from an empty heap reports nothing held and no key
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status == bmhq_pkg::ST_EMPTY |-> rsp_fill_level == '0
                                                  && rsp_key_out == '0)
      else $error("empty status with keys held or a key returned");

   // dropped insert only when the heap is at capacity
   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_status == bmhq_pkg::ST_FULL |-> rsp_fill_level == FW'(CAPACITY)
                                                 && rsp_key_out == '0)
      else $error("full status below capacity");

endmodule

bind binary_min_heap_queue bmhq_checker #(
   .CAPACITY  (CAPACITY),
   .KEY_WIDTH (KEY_WIDTH)
) u_bmhq_checker (.*);

// File: tb/tb_binary_min_heap_queue.sv
// tb_binary_min_heap_queue: self-checking testbench for the binary min-heap queue
// depends on bmhq_pkg and binary_min_heap_queue; keeps its own heap to predict every result beat

module tb_binary_min_heap_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP        = 64;
   localparam int KEY_W      = 32;
   localparam int FILL_W     = $clog2(CAP + 1);
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_WAIT = 40;

   // one predicted result beat
   typedef struct {
      logic [KEY_W-1:0]     key_out;
      bmhq_pkg::status_type status;
      logic [FILL_W-1:0]    fill_level;
   } heap_result_type;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   logic              req_mode;
   logic [KEY_W-1:0]  req_key_in;
   logic              empty;
   logic              pop;
   logic [KEY_W-1:0]  rsp_key_out;
   logic [1:0]        rsp_status;
   logic [FILL_W-1:0] rsp_fill_level;

   // predictor state: 1-based heap of signed keys
   logic signed [KEY_W-1:0] heap_keys [1:CAP];
   int                      heap_size;

   heap_result_type pending_results [$];
   heap_result_type oldest;

   bit no_idle;
   int fail_count;
   int checked_count;
   int idle_cycles;
   int insert_count;
   int remove_count;
   int full_count;
   int empty_count;

   binary_min_heap_queue #(
      .CAPACITY  (CAP),
      .KEY_WIDTH (KEY_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_mode       (req_mode),
      .req_key_in     (req_key_in),
      .empty          (empty),
      .pop            (pop),
      .rsp_key_out    (rsp_key_out),
      .rsp_status     (rsp_status),
      .rsp_fill_level (rsp_fill_level)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // apply one operation to the heap copy and return the result it gives
   function automatic heap_result_type heap_apply(bmhq_pkg::op_type op,
                                                  logic signed [KEY_W-1:0] key);
      heap_result_type         r;
      int                      pos;
      int                      child;
      bit                      settled;
      logic signed [KEY_W-1:0] held;
      r.key_out = '0;
      r.status  = bmhq_pkg::ST_DONE;
      if (op == bmhq_pkg::OP_INSERT) begin
         if (heap_size >= CAP) begin
            r.status = bmhq_pkg::ST_FULL;
         end else begin
            heap_size++;
            heap_keys[heap_size] = key;
            pos = heap_size;
            // climb while the parent is strictly greater
            while (pos > 1 && heap_keys[pos / 2] > heap_keys[pos]) begin
               held                = heap_keys[pos / 2];
               heap_keys[pos / 2]  = heap_keys[pos];
               heap_keys[pos]      = held;
               pos                 = pos / 2;
            end
         end
      end else if (heap_size == 0) begin
         r.status = bmhq_pkg::ST_EMPTY;
      end else begin
         r.key_out    = heap_keys[1];
         heap_keys[1] = heap_keys[heap_size];
         heap_size--;
         pos     = 1;
         settled = 1'b0;
         // descend: right child only when the left is strictly greater
         while (!settled && 2 * pos <= heap_size) begin
            child = 2 * pos;
            if (child < heap_size && heap_keys[child] > heap_keys[child + 1])
               child++;
            if (heap_keys[pos] <= heap_keys[child]) begin
               settled = 1'b1;
            end else begin
               held             = heap_keys[pos];
               heap_keys[pos]   = heap_keys[child];
               heap_keys[child] = held;
               pos              = child;
            end
         end
      end
      r.fill_level = FILL_W'(heap_size);
      return r;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   // keys: full range, a narrow band for ties, and the extremes
   function automatic logic [KEY_W-1:0] rand_key();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: rand_key = {1'b0, {(KEY_W-1){1'b1}}};
         1: rand_key = {1'b1, {(KEY_W-1){1'b0}}};
         2, 3, 4: rand_key = KEY_W'($urandom_range(0, 16)) - KEY_W'(8);
         default: rand_key = KEY_W'($urandom);
      endcase
   endfunction

   // send one request beat; called and returns at a falling edge
   task automatic send_beat(bmhq_pkg::op_type op, logic [KEY_W-1:0] key);
      int              gap;
      heap_result_type r;
      gap = draw_gap();
      if (gap > 0) begin
         push       <= 1'b0;
         req_mode   <= 1'($urandom);
         req_key_in <= KEY_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      push       <= 1'b1;
      req_mode   <= op;
      req_key_in <= key;
      do @(posedge clock); while (full);
      r = heap_apply(op, key);
      pending_results.push_back(r);
      if (op == bmhq_pkg::OP_INSERT) insert_count++;
      else                           remove_count++;
      if (r.status == bmhq_pkg::ST_FULL)  full_count++;
      if (r.status == bmhq_pkg::ST_EMPTY) empty_count++;
      @(negedge clock);
   endtask

   // result side: random stalls before each beat
   initial begin
      int gap;
      pop = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         @(negedge clock);
      end
   end

   // compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat: key %0d status %0d fill %0d", $realtime,
                     $signed(rsp_key_out), rsp_status, rsp_fill_level);
            fail_count++;
         end else begin
            oldest = pending_results.pop_front();
            checked_count++;
            if (rsp_key_out !== oldest.key_out) begin
               $display("%0t: key_out expected %0d, got %0d", $realtime,
                        $signed(oldest.key_out), $signed(rsp_key_out));
               fail_count++;
            end
            if (rsp_status !== oldest.status) begin
               $display("%0t: status expected %0d, got %0d", $realtime,
                        oldest.status, rsp_status);
               fail_count++;
            end
            if (rsp_fill_level !== oldest.fill_level) begin
               $display("%0t: fill_level expected %0d, got %0d", $realtime,
                        oldest.fill_level, rsp_fill_level);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
                     $realtime, IDLE_LIMIT, pending_results.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // removes on an empty heap, key ignored
   task automatic test_remove_empty();
      send_beat(bmhq_pkg::OP_REMOVE, '1);
      send_beat(bmhq_pkg::OP_REMOVE, rand_key());
   endtask

   // extreme keys in and out, finishing on an empty remove
   task automatic test_key_extremes();
      send_beat(bmhq_pkg::OP_INSERT, '0);
      send_beat(bmhq_pkg::OP_INSERT, {1'b0, {(KEY_W-1){1'b1}}});
      send_beat(bmhq_pkg::OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}});
      send_beat(bmhq_pkg::OP_INSERT, '1);
      send_beat(bmhq_pkg::OP_INSERT, KEY_W'(1));
      send_beat(bmhq_pkg::OP_INSERT, {1'b1, {(KEY_W-2){1'b0}}, 1'b1});
      repeat (7) send_beat(bmhq_pkg::OP_REMOVE, rand_key());
   endtask

   // ties on the way up and down
   task automatic test_equal_keys();
      send_beat(bmhq_pkg::OP_INSERT, KEY_W'(5));
      send_beat(bmhq_pkg::OP_INSERT, KEY_W'(5));
      send_beat(bmhq_pkg::OP_INSERT, KEY_W'(5));
      send_beat(bmhq_pkg::OP_INSERT, -KEY_W'(3));
      send_beat(bmhq_pkg::OP_INSERT, KEY_W'(5));
      repeat (5) send_beat(bmhq_pkg::OP_REMOVE, '0);
   endtask

   // descending keys climb to the root every time, then overflow and drain
   task automatic test_fill_and_drain();
      int i;
      for (i = 0; i < CAP + 2; i++)
         send_beat(bmhq_pkg::OP_INSERT,
                   KEY_W'(100000 - i * 1000 + $urandom_range(0, 999)));
      for (i = 0; i < CAP + 1; i++)
         send_beat(bmhq_pkg::OP_REMOVE, rand_key());
   endtask

   // random mix, phases of insert or remove bias and of back-to-back traffic
   task automatic test_random_mix(int count);
      int               i;
      int               bias;
      bmhq_pkg::op_type op;
      bias = 50;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            bias    = 10 + 20 * $urandom_range(0, 4);
            no_idle = ($urandom_range(0, 3) == 0);
         end
         op = ($urandom_range(0, 99) < bias) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_REMOVE;
         send_beat(op, rand_key());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      push       = 1'b0;
      req_mode   = 1'b0;
      req_key_in = '0;
      no_idle    = 1'b0;
      heap_size  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_remove_empty();
      test_key_extremes();
      test_equal_keys();
      test_fill_and_drain();
      test_random_mix(400);
      push <= 1'b0;

      // wait for every predicted beat, then a little longer for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d inserts (%0d refused on a full heap), %0d removes (%0d on empty)",
               insert_count, full_count, remove_count, empty_count);
      $display("%0d result beats checked, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
